### design/assert_macros.svh
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_PROP(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	`ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

### design/lfr_pkg.sv
`default_nettype none
package lfr_pkg;

	localparam logic [7:0]  ADDR_PRIMARY   = 8'h03;
	localparam logic [7:0]  ADDR_SECONDARY = 8'h01;
	localparam logic [7:0]  CTRL_NIBBLE    = 8'h0F;

	localparam logic [7:0]  FLAG_RESET     = 8'h7E;
	localparam logic [15:0] MASK_RESET     = 16'h0000;
	localparam logic [15:0] MAX_RESET      = 16'd1024;

	typedef enum logic [1:0] {
		REG_FLAG     = 2'd0,
		REG_MASK     = 2'd1,
		REG_MAX      = 2'd2,
		REG_RESERVED = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_END      = 2'd1,
		KIND_OVERFLOW = 2'd2,
		KIND_UNUSED   = 2'd3
	} event_kind_t;

	typedef enum logic [5:0] {
		ST_START = 6'b000001,
		ST_FLAG  = 6'b000010,
		ST_ADDR  = 6'b000100,
		ST_CTRL  = 6'b001000,
		ST_HDR   = 6'b010000,
		ST_DATA  = 6'b100000
	} rx_state_t;

endpackage
`default_nettype wire

### design/link_frame_receiver_unit.sv
// link frame receiver: finds frames of the form flag, address, control,
// header check, payload bytes, flag in a stream of received bytes.
// input channel: rx_byte with in_valid / in_stall; a byte is taken at a
// clock edge with in_valid high and in_stall low, one byte per cycle.
// output channel: event_kind, payload_byte, byte_index, control_byte and
// payload_count with out_valid / out_stall; a payload byte gives one event,
// a closing flag gives a frame-complete event, a payload count reaching
// max_payload gives an overflow event; header bytes give none.
// the event for a byte is registered and on the output in the cycle after
// the byte is taken. throughput: one byte per cycle while in_stall is low, set
// by the single state update between the frame state and output registers.
// when out_stall holds a waiting event, in_stall rises in the same cycle
// and stays high until the event is taken; no event is dropped.
// configuration: cfg_we writes cfg_data to register cfg_index (0 flag value,
// 1 valid control mask, 2 max payload); write only while no event is pending.
// reset (arst_n low): the receiver returns to the start state hunting for a
// flag, the output is empty, registers take 0x7e, 0x0000 and 1024.
`default_nettype none
`include "assert_macros.svh"
module link_frame_receiver_unit
	import lfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       event_kind,
	output logic [7:0]       payload_byte,
	output logic [15:0]      byte_index,
	output logic [7:0]       control_byte,
	output logic [15:0]      payload_count
);

	logic [7:0]  flag_q;
	logic [15:0] mask_q;
	logic [15:0] max_q;

	rx_state_t   state_q, state_d;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic [15:0] count_q, count_d;

	logic        out_valid_q;
	event_kind_t kind_q, kind_d;
	logic [7:0]  pbyte_q, pbyte_d;
	logic [15:0] index_q, index_d;
	logic [7:0]  cbyte_q, cbyte_d;
	logic [15:0] pcount_q, pcount_d;
	logic        has_res;

	logic        in_acc;
	logic        is_flag;
	logic        addr_ok;
	logic        ctrl_ok;
	logic        hdr_ok;
	logic [16:0] next_cnt;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign is_flag  = (rx_byte == flag_q);
	assign addr_ok  = (rx_byte == ADDR_PRIMARY) || (rx_byte == ADDR_SECONDARY);
	assign ctrl_ok  = mask_q[4'(rx_byte & CTRL_NIBBLE)];
	assign hdr_ok   = ((addr_q ^ ctrl_q ^ rx_byte) == 8'h00);
	assign next_cnt = {1'b0, count_q} + 17'd1;

	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		ctrl_d   = ctrl_q;
		count_d  = count_q;
		has_res  = 1'b0;
		kind_d   = KIND_PAYLOAD;
		pbyte_d  = '0;
		index_d  = '0;
		cbyte_d  = '0;
		pcount_d = '0;
		case (state_q)
			ST_FLAG: begin
				if (addr_ok) begin
					addr_d  = rx_byte;
					state_d = ST_ADDR;
				end else if (!is_flag) begin
					state_d = ST_START;
				end
			end
			ST_ADDR: begin
				if (ctrl_ok) begin
					ctrl_d  = rx_byte;
					state_d = ST_CTRL;
				end else begin
					state_d = is_flag ? ST_FLAG : ST_START;
				end
			end
			ST_CTRL: begin
				if (hdr_ok) state_d = ST_HDR;
				else state_d = is_flag ? ST_FLAG : ST_START;
			end
			ST_HDR, ST_DATA: begin
				has_res = 1'b1;
				if (is_flag) begin
					kind_d   = KIND_END;
					cbyte_d  = ctrl_q;
					pcount_d = count_q;
					count_d  = '0;
					state_d  = ST_START;
				end else if (state_q == ST_HDR) begin
					// first payload byte skips the overflow test
					pbyte_d = rx_byte;
					count_d = 16'd1;
					state_d = ST_DATA;
				end else if (next_cnt >= {1'b0, max_q}) begin
					kind_d   = KIND_OVERFLOW;
					pcount_d = next_cnt[15:0];
					count_d  = '0;
					state_d  = ST_START;
				end else begin
					pbyte_d = rx_byte;
					index_d = count_q;
					count_d = next_cnt[15:0];
				end
			end
			default: begin
				state_d = is_flag ? ST_FLAG : ST_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= FLAG_RESET;
			mask_q <= MASK_RESET;
			max_q  <= MAX_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FLAG: flag_q <= cfg_data[7:0];
				REG_MASK: mask_q <= cfg_data;
				REG_MAX:  max_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			addr_q  <= '0;
			ctrl_q  <= '0;
			count_q <= '0;
		end else if (in_acc) begin
			state_q <= state_d;
			addr_q  <= addr_d;
			ctrl_q  <= ctrl_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// event payload, loaded only when the output slot is free or being taken
	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			kind_q   <= kind_d;
			pbyte_q  <= pbyte_d;
			index_q  <= index_d;
			cbyte_q  <= cbyte_d;
			pcount_q <= pcount_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = kind_q;
	assign payload_byte  = pbyte_q;
	assign byte_index    = index_q;
	assign control_byte  = cbyte_q;
	assign payload_count = pcount_q;

	`ASSERT_IMPL(a_kind_legal, out_valid_q, kind_q != KIND_UNUSED, "illegal event kind")
	`ASSERT_IMPL(a_payload_clean, out_valid_q && kind_q == KIND_PAYLOAD,
		cbyte_q == 8'h00 && pcount_q == 16'd0, "payload event carries frame fields")
	`ASSERT_NEXT(a_first_payload, in_acc && state_q == ST_HDR && !is_flag,
		state_q == ST_DATA && count_q == 16'd1 && out_valid_q, "first payload byte lost")

endmodule
`default_nettype wire

### sim/tb.sv
module tb;
	import lfr_pkg::*;

	typedef struct {
		event_kind_t kind;
		logic [7:0]  data;
		logic [15:0] index;
		logic [7:0]  ctrl;
		logic [15:0] count;
	} rx_event_t;

	localparam int LONG_HOLD      = 200;
	localparam int LOG_LIMIT      = 40;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_FLAG;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [7:0]  control_byte;
	logic [15:0] payload_count;

	// frame tracker mirroring the receiver, with its own copy of the registers
	rx_state_t   fr_state = ST_START;
	logic [7:0]  fr_addr = '0;
	logic [7:0]  fr_ctrl = '0;
	logic [15:0] fr_count = '0;
	logic [7:0]  cur_flag = FLAG_RESET;
	logic [15:0] cur_mask = MASK_RESET;
	logic [15:0] cur_max = MAX_RESET;

	logic [7:0]  rx_stream[$];
	rx_event_t   due_events[$];
	rx_event_t   want;
	int          gen_count = 0;
	int          err_count = 0;
	int          send_wait = 0;
	int          recv_wait = 0;
	int          send_gap_max = 16;
	int          recv_gap_max = 16;
	int          hold_asked = 0;
	int          hold_taken = 0;

	logic [7:0] opening_bytes[$] = '{
		// doubled opening flag, payload extremes, closing flag
		FLAG_RESET, FLAG_RESET, ADDR_PRIMARY, 8'h0F, 8'h0C, 8'h00, 8'hFF, FLAG_RESET,
		// address right after a closing flag is ignored, then an empty frame
		ADDR_SECONDARY, FLAG_RESET, ADDR_SECONDARY, 8'h80, 8'h81, FLAG_RESET,
		// bad address falls back to start
		FLAG_RESET, 8'h02,
		// control and header failures on the flag, then overflow at the limit
		FLAG_RESET, ADDR_PRIMARY, FLAG_RESET, ADDR_SECONDARY, 8'hF0, FLAG_RESET,
		ADDR_PRIMARY, 8'hFF, 8'hFC, 8'hAA, 8'hBB, 8'hCC
	};

	link_frame_receiver_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.control_byte (control_byte),
		.payload_count(payload_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rx_state_t fall_back(input logic [7:0] b);
		if (b == cur_flag)
			return ST_FLAG;
		return ST_START;
	endfunction

	task automatic track_rx_byte(input logic [7:0] b);
		logic [16:0] next_count;
		rx_event_t   ev;
		ev.kind = KIND_PAYLOAD;
		ev.data = '0;
		ev.index = '0;
		ev.ctrl = '0;
		ev.count = '0;
		case (fr_state)
		ST_FLAG: begin
			if (b == ADDR_PRIMARY || b == ADDR_SECONDARY) begin
				fr_addr = b;
				fr_state = ST_ADDR;
			end else if (b != cur_flag) begin
				fr_state = ST_START;
			end
		end
		ST_ADDR: begin
			if (cur_mask[4'(b & CTRL_NIBBLE)]) begin
				fr_ctrl = b;
				fr_state = ST_CTRL;
			end else begin
				fr_state = fall_back(b);
			end
		end
		ST_CTRL: begin
			if ((fr_addr ^ fr_ctrl ^ b) == 8'h00)
				fr_state = ST_HDR;
			else
				fr_state = fall_back(b);
		end
		ST_HDR, ST_DATA: begin
			if (b == cur_flag) begin
				ev.kind = KIND_END;
				ev.ctrl = fr_ctrl;
				ev.count = fr_count;
				fr_count = '0;
				fr_state = ST_START;
			end else if (fr_state == ST_HDR) begin
				// first payload byte skips the limit test
				ev.data = b;
				fr_count = 16'd1;
				fr_state = ST_DATA;
			end else begin
				next_count = {1'b0, fr_count} + 17'd1;
				if (next_count >= {1'b0, cur_max}) begin
					ev.kind = KIND_OVERFLOW;
					ev.count = next_count[15:0];
					fr_count = '0;
					fr_state = ST_START;
				end else begin
					ev.data = b;
					ev.index = fr_count;
					fr_count = next_count[15:0];
				end
			end
			due_events.push_back(ev);
		end
		default: begin
			fr_state = fall_back(b);
		end
		endcase
	endtask

	task automatic log_mismatch(input string what);
		if (err_count < LOG_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	// byte source
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			track_rx_byte(rx_byte);
		if (!in_valid || !in_stall) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (rx_stream.size() != 0) begin
				in_valid <= 1'b1;
				rx_byte <= rx_stream.pop_front();
				send_wait = $urandom_range(send_gap_max, 0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// event sink and checker
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (due_events.size() == 0) begin
				log_mismatch($sformatf("event kind %0d with nothing due", event_kind));
			end else begin
				want = due_events.pop_front();
				if (event_kind !== want.kind)
					log_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
				if (payload_byte !== want.data)
					log_mismatch($sformatf("payload_byte %h, want %h", payload_byte, want.data));
				if (byte_index !== want.index)
					log_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.index));
				if (control_byte !== want.ctrl)
					log_mismatch($sformatf("control_byte %h, want %h", control_byte, want.ctrl));
				if (payload_count !== want.count)
					log_mismatch($sformatf("payload_count %0d, want %0d",
						payload_count, want.count));
			end
		end
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			recv_wait = LONG_HOLD;
		end else if (out_valid && !out_stall) begin
			recv_wait = $urandom_range(recv_gap_max, 0);
		end
		if (recv_wait > 0) begin
			recv_wait--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		gen_count++;
	endtask

	function automatic logic [7:0] pick_ctrl(input logic accept);
		logic [7:0] b;
		b = 8'($urandom);
		for (int i = 0; i < 64 && cur_mask[4'(b & CTRL_NIBBLE)] != accept; i++)
			b = 8'($urandom);
		return b;
	endfunction

	function automatic logic [7:0] payload_pick(input logic clean);
		logic [7:0] b;
		b = 8'($urandom);
		// an early flag closes the frame, keep it rare
		if (b == cur_flag && (clean || $urandom_range(19) != 0))
			b = ~b;
		return b;
	endfunction

	function automatic logic [7:0] off_address();
		logic [7:0] b;
		if ($urandom_range(3) == 0)
			return cur_flag;
		b = 8'($urandom);
		while (b == ADDR_PRIMARY || b == ADDR_SECONDARY)
			b = 8'($urandom);
		return b;
	endfunction

	task automatic push_frame(input logic [7:0] addr, input logic [7:0] ctrl,
			input logic [7:0] chk, input int n_pay, input logic close, input logic clean);
		push_byte(cur_flag);
		push_byte(addr);
		push_byte(ctrl);
		push_byte(chk);
		repeat (n_pay)
			push_byte(payload_pick(clean));
		if (close)
			push_byte(cur_flag);
	endtask

	task automatic push_random_frame();
		int         pick;
		int         n_pay;
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [7:0] chk;
		pick = $urandom_range(99);
		if ($urandom_range(4) == 0)
			push_byte(cur_flag);
		addr = $urandom_range(1) ? ADDR_PRIMARY : ADDR_SECONDARY;
		ctrl = pick_ctrl(1'b1);
		chk = addr ^ ctrl;
		n_pay = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(60, 9);
		if (pick < 70) begin
			push_frame(addr, ctrl, chk, n_pay, $urandom_range(15) != 0, 1'b0);
		end else if (pick < 78) begin
			repeat ($urandom_range(4, 1))
				rx_stream.push_back(8'($urandom));
		end else if (pick < 86) begin
			push_byte(cur_flag);
			push_byte(off_address());
		end else if (pick < 93) begin
			push_byte(cur_flag);
			push_byte(addr);
			push_byte(($urandom_range(3) == 0) ? cur_flag : pick_ctrl(1'b0));
		end else begin
			push_byte(cur_flag);
			push_byte(addr);
			push_byte(ctrl);
			push_byte(($urandom_range(3) == 0) ? cur_flag : chk ^ 8'($urandom_range(255, 1)));
		end
	endtask

	task automatic fill_random(input int n);
		gen_count = 0;
		while (gen_count < n)
			push_random_frame();
	endtask

	task automatic drain();
		while (rx_stream.size() != 0 || in_valid || due_events.size() != 0)
			@(negedge clk);
		// header bytes give no event but may still be in flight
		repeat (4) @(negedge clk);
	endtask

	task automatic program_regs(input logic [7:0] flag, input logic [15:0] mask,
			input logic [15:0] limit);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FLAG;
		cfg_data <= {8'h00, flag};
		@(posedge clk);
		cfg_index <= REG_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= REG_MAX;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_flag = flag;
		cur_mask = mask;
		cur_max = limit;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] flag, input logic [15:0] mask,
			input logic [15:0] limit, input int sgap, input int rgap, input int n,
			input logic hold);
		program_regs(flag, mask, limit);
		send_gap_max = sgap;
		recv_gap_max = rgap;
		if (hold)
			hold_asked++;
		fill_random(n);
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// register defaults: an empty control mask rejects every frame
		fill_random(40);
		drain();

		program_regs(FLAG_RESET, 16'h8001, 16'd3);
		foreach (opening_bytes[i])
			rx_stream.push_back(opening_bytes[i]);
		drain();

		run_phase(FLAG_RESET, 16'($urandom_range(65535, 1)), MAX_RESET, 16, 16, 250, 1'b0);
		run_phase(8'h00, 16'hFFFF, 16'd2, 16, 16, 200, 1'b0);
		run_phase(8'hFF, 16'h0001, 16'($urandom_range(40, 3)), 0, 0, 200, 1'b0);
		// sink holds off while bytes keep coming
		run_phase(8'($urandom), 16'($urandom), 16'($urandom_range(12, 2)), 0, 8, 250, 1'b1);

		// one long clean frame stays under the largest limit
		program_regs(FLAG_RESET, 16'hFFFF, 16'hFFFF);
		send_gap_max = 0;
		recv_gap_max = 0;
		push_frame(ADDR_PRIMARY, 8'h00, ADDR_PRIMARY, 60, 1'b1, 1'b1);
		fill_random(20);
		drain();

		run_phase(8'h5A, MASK_RESET, 16'($urandom_range(65535, 2)), 16, 16, 100, 1'b0);

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 12);
		$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/lfr_pkg.sv
design/link_frame_receiver_unit.sv
sim/tb.sv
